FILE: sv/pah_pkg.sv
// ----------------------------------------------------------------------------
// pah_pkg
// Shared types and constants for the Poisson arrival histogram block.
// ----------------------------------------------------------------------------
package pah_pkg;

    localparam int NUM_BINS    = 25;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int BIN_IDX_W   = 5;
    localparam int SEL_W       = 5;
    localparam int DATA_W      = 32;
    localparam int SUM_W       = 48;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;

    localparam int IN_FIELDS_W = DATA_W + SEL_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int OUT_FIELDS_W = 1 + DATA_W + BIN_IDX_W + DATA_W + DATA_W + SUM_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENTS = 2'd2;

    localparam logic [DATA_W-1:0] RST_THRESHOLD  = 32'd4295;
    localparam logic [DATA_W-1:0] RST_BIN_WIDTH  = 32'd200000;
    localparam logic [DATA_W-1:0] RST_MAX_EVENTS = 32'd1000;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef logic [BIN_W-1:0] bin_idx_t;

    function automatic logic [DATA_W-1:0] sat_inc32(input logic [DATA_W-1:0] v);
        sat_inc32 = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

FILE: sv/poisson_arrival_histogram.sv
// ----------------------------------------------------------------------------
// poisson_arrival_histogram
// Bernoulli arrival generator with a saturating interval histogram.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel. s_tuser selects a tick (0) or a bin
// read (1); s_tdata carries the random sample and the bin to read. Each
// request gives exactly one result on the m_ channel.
// The cfg_ channel writes the threshold, the bin width and the event limit;
// cfg_ready is always high and writes are expected only while the block is
// idle.
// A tick without an event or a tick after the limit goes straight to the
// finish state, and a bin read passes through the readout state first. A tick
// that fires an event runs a restoring divider over the bin width, one
// quotient bit a cycle, then a read and a write of the histogram memory, and
// then reaches the finish state, which loads the output register.
// s_tready is high only while the sequencer is idle, so no request is taken
// before the previous result has been loaded into the output register, and
// the next one can be taken as soon as the sequencer is back in idle, even if
// that result is still waiting.
// When the receiver stalls, the finished result is held until the output
// register frees, and no further request is accepted meanwhile.
// Reset clears the counters, the registers to their defaults and the valid
// bit of every histogram bin, so that each bin reads as zero until written.
// ----------------------------------------------------------------------------
module poisson_arrival_histogram
    import pah_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // random_sample [31:0], bin_select [36:32], zero padding.
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    // kind [0].
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // event_fired [0], interval_ticks [32:1], bin_slot [37:33],
    // bin_count [69:38], events_so_far [101:70], interval_sum [149:102],
    // done_res [150], zero padding.
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]       cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_BRD   = 3'd2;
    localparam logic [2:0] ST_BWR   = 3'd3;
    localparam logic [2:0] ST_RDOUT = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [DATA_W-1:0]   thr_reg, thr_next;
    logic [DATA_W-1:0]   bw_reg, bw_next;
    logic [DATA_W-1:0]   maxev_reg, maxev_next;
    logic [DATA_W-1:0]   ticks_reg, ticks_next;
    logic [DATA_W-1:0]   evt_reg, evt_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [NUM_BINS-1:0] valid_reg, valid_next;
    logic [DATA_W-1:0]   div_rem_reg, div_rem_next;
    logic [DATA_W-1:0]   div_q_reg, div_q_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    bin_idx_t            bin_reg, bin_next;
    logic                sel_ok_reg, sel_ok_next;
    logic                res_fired_reg, res_fired_next;
    logic [DATA_W-1:0]   res_interval_reg, res_interval_next;
    logic [DATA_W-1:0]   res_count_reg, res_count_next;

    logic                m_valid_reg, m_valid_next;
    logic                o_fired_reg, o_fired_next;
    logic [DATA_W-1:0]   o_interval_reg, o_interval_next;
    logic [BIN_IDX_W-1:0] o_bin_reg, o_bin_next;
    logic [DATA_W-1:0]   o_count_reg, o_count_next;
    logic [DATA_W-1:0]   o_events_reg, o_events_next;
    logic [SUM_W-1:0]    o_sum_reg, o_sum_next;
    logic                o_done_reg, o_done_next;

    logic [DATA_W-1:0]   hist_mem [NUM_BINS];
    logic [DATA_W-1:0]   hist_rd_reg;
    logic                hist_v_reg;
    bin_idx_t            rd_addr;
    logic                mem_we;
    logic [DATA_W-1:0]   mem_wdata;

    logic [DATA_W-1:0]   in_sample;
    logic [SEL_W-1:0]    in_sel;
    logic                in_kind;
    logic                in_sel_ok;
    logic                s_accept;

    logic [DATA_W:0]     div_shift;
    logic [DATA_W+1:0]   div_diff;
    logic                div_ge;
    logic [DATA_W-1:0]   div_q_step;
    logic [SUM_W:0]      acc_sum;

    assign in_sample = s_tdata[DATA_W-1:0];
    assign in_sel    = s_tdata[DATA_W+SEL_W-1:DATA_W];
    assign in_kind   = s_tuser;
    assign in_sel_ok = (32'(in_sel) < 32'(NUM_BINS));
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign rd_addr = (state_reg == ST_IDLE) ? (in_sel_ok ? BIN_W'(in_sel) : '0) : bin_reg;

    assign div_shift  = {div_rem_reg, div_q_reg[DATA_W-1]};
    assign div_diff   = {1'b0, div_shift} - {2'b00, bw_reg};
    assign div_ge     = ~div_diff[DATA_W+1];
    assign div_q_step = {div_q_reg[DATA_W-2:0], div_ge};

    assign acc_sum = {1'b0, acc_reg} + {{(SUM_W-DATA_W+1){1'b0}}, ticks_reg};

    always_comb begin
        state_next        = state_reg;
        thr_next          = thr_reg;
        bw_next           = bw_reg;
        maxev_next        = maxev_reg;
        ticks_next        = ticks_reg;
        evt_next          = evt_reg;
        acc_next          = acc_reg;
        valid_next        = valid_reg;
        div_rem_next      = div_rem_reg;
        div_q_next        = div_q_reg;
        div_cnt_next      = div_cnt_reg;
        bin_next          = bin_reg;
        sel_ok_next       = sel_ok_reg;
        res_fired_next    = res_fired_reg;
        res_interval_next = res_interval_reg;
        res_count_next    = res_count_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        o_fired_next      = o_fired_reg;
        o_interval_next   = o_interval_reg;
        o_bin_next        = o_bin_reg;
        o_count_next      = o_count_reg;
        o_events_next     = o_events_reg;
        o_sum_next        = o_sum_reg;
        o_done_next       = o_done_reg;
        mem_we            = 1'b0;
        mem_wdata         = '0;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_THRESHOLD:  thr_next   = cfg_data;
                CFG_BIN_WIDTH:  bw_next    = cfg_data;
                CFG_MAX_EVENTS: maxev_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_fired_next    = 1'b0;
                    res_interval_next = '0;
                    res_count_next    = '0;
                    bin_next          = '0;
                    if (in_kind == KIND_READ) begin
                        sel_ok_next = in_sel_ok;
                        state_next  = ST_RDOUT;
                    end else if (evt_reg < maxev_reg) begin
                        if (in_sample <= thr_reg) begin
                            res_fired_next    = 1'b1;
                            res_interval_next = ticks_reg;
                            acc_next          = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
                            evt_next          = sat_inc32(evt_reg);
                            ticks_next        = 32'd1;
                            div_rem_next      = '0;
                            div_q_next        = ticks_reg;
                            div_cnt_next      = '0;
                            state_next        = ST_DIV;
                        end else begin
                            ticks_next = sat_inc32(ticks_reg);
                            state_next = ST_FIN;
                        end
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DIV: begin
                div_rem_next = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
                div_q_next   = div_q_step;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    bin_next   = (div_q_step >= 32'(NUM_BINS - 1)) ?
                                 BIN_W'(NUM_BINS - 1) : div_q_step[BIN_W-1:0];
                    state_next = ST_BRD;
                end
            end
            ST_BRD: begin
                state_next = ST_BWR;
            end
            ST_BWR: begin
                mem_we              = 1'b1;
                mem_wdata           = hist_v_reg ? sat_inc32(hist_rd_reg) : 32'd1;
                valid_next[bin_reg] = 1'b1;
                state_next          = ST_FIN;
            end
            ST_RDOUT: begin
                res_count_next = (sel_ok_reg && hist_v_reg) ? hist_rd_reg : '0;
                state_next     = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    o_fired_next    = res_fired_reg;
                    o_interval_next = res_interval_reg;
                    o_bin_next      = BIN_IDX_W'(bin_reg);
                    o_count_next    = res_count_reg;
                    o_events_next   = evt_reg;
                    o_sum_next      = acc_reg;
                    o_done_next     = (evt_reg >= maxev_reg);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= RST_THRESHOLD;
            bw_reg      <= RST_BIN_WIDTH;
            maxev_reg   <= RST_MAX_EVENTS;
            ticks_reg   <= '0;
            evt_reg     <= '0;
            acc_reg     <= '0;
            valid_reg   <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            bw_reg      <= bw_next;
            maxev_reg   <= maxev_next;
            ticks_reg   <= ticks_next;
            evt_reg     <= evt_next;
            acc_reg     <= acc_next;
            valid_reg   <= valid_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_rem_reg      <= div_rem_next;
        div_q_reg        <= div_q_next;
        bin_reg          <= bin_next;
        sel_ok_reg       <= sel_ok_next;
        res_fired_reg    <= res_fired_next;
        res_interval_reg <= res_interval_next;
        res_count_reg    <= res_count_next;
        o_fired_reg      <= o_fired_next;
        o_interval_reg   <= o_interval_next;
        o_bin_reg        <= o_bin_next;
        o_count_reg      <= o_count_next;
        o_events_reg     <= o_events_next;
        o_sum_reg        <= o_sum_next;
        o_done_reg       <= o_done_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[bin_reg] <= mem_wdata;
        end
        hist_rd_reg <= hist_mem[rd_addr];
        hist_v_reg  <= valid_reg[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, o_done_reg, o_sum_reg,
                       o_events_reg, o_count_reg, o_bin_reg, o_interval_reg, o_fired_reg};

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Poisson arrival histogram block.
// ----------------------------------------------------------------------------
// Tick and bin-read requests are queued by the stimulus process and offered
// on the s_ channel by a clocked driver. A clocked monitor predicts the
// result of every accepted request and checks each m_ result against the
// oldest prediction, field by field. A directed opening covers the register
// extremes, the event limit, a zero bin width and out-of-range reads. Random
// phases then follow under several register settings and handshake pacings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pah_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ERROR_PRINT_LIMIT = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [BIN_IDX_W-1:0] LAST_BIN = BIN_IDX_W'(NUM_BINS - 1);

    localparam int OFS_GAP  = 1;
    localparam int OFS_BIN  = OFS_GAP + DATA_W;
    localparam int OFS_CNT  = OFS_BIN + BIN_IDX_W;
    localparam int OFS_EVT  = OFS_CNT + DATA_W;
    localparam int OFS_SUM  = OFS_EVT + DATA_W;
    localparam int OFS_DONE = OFS_SUM + SUM_W;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] sample;
        logic [SEL_W-1:0]  sel;
    } arrival_req_t;

    typedef struct packed {
        logic                 fired;
        logic [DATA_W-1:0]    gap;
        logic [BIN_IDX_W-1:0] bin_idx;
        logic [DATA_W-1:0]    bin_count;
        logic [DATA_W-1:0]    arrivals;
        logic [SUM_W-1:0]     gap_sum;
        logic                 done;
    } arrival_res_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = KIND_TICK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_THRESHOLD;
    logic [DATA_W-1:0]      cfg_data = '0;

    poisson_arrival_histogram DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted copy of the block's registers and state.
    logic [DATA_W-1:0] thr_reg   = RST_THRESHOLD;
    logic [DATA_W-1:0] width_reg = RST_BIN_WIDTH;
    logic [DATA_W-1:0] limit_reg = RST_MAX_EVENTS;
    logic [DATA_W-1:0] arr_gap   = '0;
    logic [DATA_W-1:0] arr_count = '0;
    logic [SUM_W-1:0]  gap_total = '0;
    logic [DATA_W-1:0] gap_hist [NUM_BINS] = '{default: '0};

    arrival_req_t pending_reqs [$];
    arrival_res_t predicted_results [$];
    arrival_req_t next_req;
    arrival_res_t model_out;
    arrival_res_t oldest;

    int  reqs_in_flight = 0;
    logic s_accepted = 1'b0;
    int  src_idle_pct = 9;
    int  snk_idle_pct = 69;
    int  sink_hold = 0;
    int  mismatches = 0;
    int  results_checked = 0;
    int  ticks_seen = 0;
    int  ticks_ignored = 0;
    int  reads_seen = 0;
    int  cfg_writes = 0;
    int  cycle_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, predicted_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= ERROR_PRINT_LIMIT) begin
            $display("ERROR cycle %0d: %s got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    function automatic logic [DATA_W-1:0] bump(input logic [DATA_W-1:0] v);
        return (v == ALL_ONES) ? v : v + 1'b1;
    endfunction

    task automatic advance_generator(input logic kind, input logic [DATA_W-1:0] sample,
                                     input logic [SEL_W-1:0] sel, output arrival_res_t r);
        logic [DATA_W-1:0]    quot;
        logic [BIN_IDX_W-1:0] slot;
        logic [SUM_W:0]       wide;
        r = '0;
        if (kind == KIND_READ) begin
            reads_seen++;
            if (sel < NUM_BINS) begin
                r.bin_count = gap_hist[sel];
            end
        end else if (arr_count < limit_reg) begin
            ticks_seen++;
            if (sample <= thr_reg) begin
                r.fired = 1'b1;
                r.gap = arr_gap;
                wide = {1'b0, gap_total} + {{(SUM_W + 1 - DATA_W){1'b0}}, arr_gap};
                gap_total = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
                quot = (width_reg == '0) ? ALL_ONES : arr_gap / width_reg;
                slot = (quot >= NUM_BINS - 1) ? LAST_BIN : quot[BIN_IDX_W-1:0];
                gap_hist[slot] = bump(gap_hist[slot]);
                r.bin_idx = slot;
                arr_count = bump(arr_count);
                arr_gap = 32'd1;
            end else begin
                arr_gap = bump(arr_gap);
            end
        end else begin
            ticks_seen++;
            ticks_ignored++;
        end
        r.arrivals = arr_count;
        r.gap_sum = gap_total;
        r.done = (arr_count >= limit_reg);
    endtask

    always @(negedge aclk) begin
        if (!s_tvalid || s_accepted) begin
            if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.kind;
                s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, next_req.sel,
                             next_req.sample};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_THRESHOLD:  thr_reg = cfg_data;
                    CFG_BIN_WIDTH:  width_reg = cfg_data;
                    CFG_MAX_EVENTS: limit_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_generator(s_tuser, s_tdata[DATA_W-1:0], s_tdata[DATA_W +: SEL_W],
                                  model_out);
                predicted_results.push_back(model_out);
                reqs_in_flight--;
            end
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", m_tdata[63:0], '0);
                end else begin
                    oldest = predicted_results.pop_front();
                    check_field("event_fired", 64'(m_tdata[0]), 64'(oldest.fired));
                    check_field("interval_ticks", 64'(m_tdata[OFS_GAP +: DATA_W]),
                                64'(oldest.gap));
                    check_field("bin_slot", 64'(m_tdata[OFS_BIN +: BIN_IDX_W]),
                                64'(oldest.bin_idx));
                    check_field("bin_count", 64'(m_tdata[OFS_CNT +: DATA_W]),
                                64'(oldest.bin_count));
                    check_field("events_so_far", 64'(m_tdata[OFS_EVT +: DATA_W]),
                                64'(oldest.arrivals));
                    check_field("interval_sum", 64'(m_tdata[OFS_SUM +: SUM_W]),
                                64'(oldest.gap_sum));
                    check_field("done_res", 64'(m_tdata[OFS_DONE]), 64'(oldest.done));
                    results_checked++;
                end
            end
        end
        s_accepted = aresetn && s_tvalid && s_tready;
    end

    task automatic push_request(input logic kind, input logic [DATA_W-1:0] sample,
                                input logic [SEL_W-1:0] sel);
        arrival_req_t req;
        req.kind = kind;
        req.sample = sample;
        req.sel = sel;
        pending_reqs.push_back(req);
        reqs_in_flight++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (reqs_in_flight != 0 || predicted_results.size() != 0);
    endtask

    task automatic random_phase(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] bw,
                                input logic [DATA_W-1:0] lim, input int n,
                                input int ev_pct, input int hold);
        logic [DATA_W-1:0] smp;
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_BIN_WIDTH, bw);
        write_reg(CFG_MAX_EVENTS, lim);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99, 0) < 15) begin
                push_request(KIND_READ, $urandom, SEL_W'($urandom_range(31, 0)));
            end else begin
                if ($urandom_range(99, 0) < ev_pct) begin
                    smp = ($urandom_range(9, 0) == 0) ? thr : $urandom_range(thr, 0);
                end else if (thr == ALL_ONES) begin
                    smp = $urandom;
                end else begin
                    smp = $urandom_range(ALL_ONES, thr + 1);
                end
                push_request(KIND_TICK, smp, SEL_W'($urandom_range(31, 0)));
            end
        end
        // Hold the receiver off so that the block fills up and stalls requests.
        sink_hold = hold;
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults, threshold boundary and out-of-range reads.
        push_request(KIND_READ, '0, 0);
        push_request(KIND_TICK, '0, 0);
        push_request(KIND_TICK, ALL_ONES, 31);
        push_request(KIND_TICK, RST_THRESHOLD, 0);
        push_request(KIND_TICK, RST_THRESHOLD + 1, 0);
        push_request(KIND_READ, '0, 0);
        push_request(KIND_READ, '0, 31);
        push_request(KIND_READ, ALL_ONES, 24);
        wait_idle();

        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_BIN_WIDTH, 1);
        write_reg(CFG_MAX_EVENTS, ALL_ONES);
        write_reg(CFG_SPARE, ALL_ONES);
        repeat (3) push_request(KIND_TICK, 1, 0);
        push_request(KIND_TICK, '0, 0);
        push_request(KIND_READ, '0, 5);
        wait_idle();

        // A zero bin width sends every event to the last bin.
        write_reg(CFG_THRESHOLD, ALL_ONES);
        write_reg(CFG_BIN_WIDTH, '0);
        push_request(KIND_TICK, ALL_ONES, 0);
        push_request(KIND_READ, '0, 24);
        push_request(KIND_READ, '0, 25);
        wait_idle();

        // Event limit at zero, then lowered below the events already seen.
        write_reg(CFG_BIN_WIDTH, ALL_ONES);
        push_request(KIND_TICK, $urandom, 0);
        wait_idle();
        write_reg(CFG_MAX_EVENTS, '0);
        push_request(KIND_TICK, '0, 0);
        push_request(KIND_READ, '0, 0);
        wait_idle();
        write_reg(CFG_MAX_EVENTS, 1);
        push_request(KIND_TICK, 5, 0);
        push_request(KIND_READ, '0, 24);
        wait_idle();

        src_idle_pct = 9;
        snk_idle_pct = 69;
        random_phase(32'h8000_0000, 1, ALL_ONES, 160, 20, 0);
        random_phase($urandom, 3, arr_count + 25, 150, 25, 0);

        src_idle_pct = 69;
        snk_idle_pct = 9;
        random_phase(32'hFFFF_FFFE, 2, ALL_ONES, 160, 10, 300);
        random_phase(1, 7, ALL_ONES, 150, 15, 0);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase($urandom, 1, ALL_ONES, 170, 30, 200);
        random_phase($urandom, $urandom_range(5, 1), ALL_ONES, 160, 20, 0);

        repeat (40) @(negedge aclk);
        if (predicted_results.size() != 0) begin
            report_mismatch("results never delivered", 64'(predicted_results.size()), '0);
        end

        $display("Covered %0d ticks (%0d ignored after the event limit), %0d bin reads, %0d events.",
                 ticks_seen, ticks_ignored, reads_seen, arr_count);
        $display("Checked %0d results over %0d register writes; %0d mismatches.",
                 results_checked, cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: poisson_arrival_histogram.f
sv/pah_pkg.sv
sv/poisson_arrival_histogram.sv
tb/testbench.sv
